// ----- rtl/psec_pkg.sv -----
// psec_pkg: shared constants and command/status types for the PSI section
// extractor. No dependencies; used by psec_ctrl, psec_dpath and the top level.
package psec_pkg;

   localparam int BYTE_W             = 8;
   localparam int LEN_W              = 12;
   localparam int LEN_SUM_W          = LEN_W + 1;
   localparam int HDR_BYTES          = 8;
   localparam int ENTRY_BASE         = 8;
   localparam int ENTRY_BYTES        = 4;
   localparam int BEAT_W             = $clog2(ENTRY_BYTES + 1);
   localparam int LEN_OVERHEAD       = 3;
   localparam int CRC_MIN_LEN        = 4;
   localparam int ENTRY_MIN_LEN      = 9;
   localparam int LEN_FIELD_HI_W     = 4;
   localparam int DEF_SECTION_BYTES  = 1024;
   localparam int DEF_MAX_PROGRAMS   = 16;

   localparam logic KIND_HEADER = 1'b0;
   localparam logic KIND_ENTRY  = 1'b1;

   typedef struct packed {
      logic take;
      logic fetch_start;
      logic fetch;
      logic load_entry;
      logic next_entry;
   } psec_cmd_type;

   typedef struct packed {
      logic done;
      logic cnt_zero;
      logic fetch_done;
      logic last_entry;
   } psec_stat_type;

endpackage

// ----- rtl/psec_ctrl.sv -----
// psec_ctrl: sequencer for the section extractor (collect, header, entry fetch,
// entry). Depends on psec_pkg; drives psec_dpath through psec_cmd_type.
module psec_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output psec_pkg::psec_cmd_type  cmd,
   input  psec_pkg::psec_stat_type stat
);

   typedef enum logic [1:0] {
      S_RUN,
      S_HDR,
      S_FETCH,
      S_ENT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_comb begin
      cmd.take        = req_valid && (state_ff == S_RUN);
      cmd.fetch_start = (state_ff == S_HDR) && rsp_ready && !stat.cnt_zero;
      cmd.fetch       = (state_ff == S_FETCH);
      cmd.load_entry  = (state_ff == S_FETCH) && stat.fetch_done;
      cmd.next_entry  = (state_ff == S_ENT) && rsp_ready && !stat.last_entry;
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      unique case (state_ff)
         S_RUN: begin
            if (cmd.take && stat.done) begin
               state_in     = S_HDR;
               rsp_valid_in = 1'b1;
            end
         end
         S_HDR: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = stat.cnt_zero ? S_RUN : S_FETCH;
            end
         end
         S_FETCH: begin
            if (stat.fetch_done) begin
               state_in     = S_ENT;
               rsp_valid_in = 1'b1;
            end
         end
         S_ENT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = stat.last_entry ? S_RUN : S_FETCH;
            end
         end
         default: begin
            state_in     = S_RUN;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_RUN);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/psec_dpath.sv -----
// psec_dpath: section store, pointer/skip tracking, header capture, entry fetch
// and result registers. Depends on psec_pkg; commanded by psec_ctrl.
module psec_dpath #(
   parameter int SECTION_BYTES = psec_pkg::DEF_SECTION_BYTES,
   parameter int MAX_PROGRAMS  = psec_pkg::DEF_MAX_PROGRAMS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  psec_pkg::psec_cmd_type  cmd,
   output psec_pkg::psec_stat_type stat,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_packet_start,
   input  logic                    req_unit_start,
   output logic                    rsp_kind,
   output logic                    rsp_last,
   output logic [7:0]              rsp_table_ident,
   output logic [11:0]             rsp_section_len,
   output logic [15:0]             rsp_id_or_program,
   output logic [4:0]              rsp_version,
   output logic                    rsp_current_next,
   output logic [7:0]              rsp_section_num,
   output logic [7:0]              rsp_last_section_num,
   output logic [31:0]             rsp_crc_or_pid,
   output logic                    rsp_next_started
);

   localparam int AW  = $clog2(SECTION_BYTES);
   localparam int WCW = $clog2(SECTION_BYTES + 1);
   localparam int PCW = $clog2(MAX_PROGRAMS + 1);
   localparam int BW  = psec_pkg::BYTE_W;
   localparam int LW  = psec_pkg::LEN_W;
   localparam int SW  = psec_pkg::LEN_SUM_W;
   localparam int QW  = LW - 2;

   // section store
   logic [BW-1:0]  mem [SECTION_BYTES];
   logic [BW-1:0]  rd_data_ff;

   // collection state
   logic [WCW-1:0] wc_ff, wc_in, wc_new;
   logic [LW-1:0]  len_ff, len_in, len_new, len_eff;
   logic [BW-1:0]  skip_ff, skip_in;
   logic           drop_ff, drop_in;
   logic           next_ff, next_in;
   logic           wr_req, wr_en, overflow, complete, emit_next;
   logic [BW-1:0]  hdr_ff [psec_pkg::HDR_BYTES];
   logic [BW-1:0]  hdr_now [psec_pkg::HDR_BYTES];
   logic [BW-1:0]  hdr_m [psec_pkg::HDR_BYTES];
   logic [3*BW-1:0] tail_ff;
   logic [31:0]    crc_word;
   logic [LW-1:0]  len_diff;
   logic [QW-1:0]  cnt_raw;
   logic [PCW-1:0] cnt_new;

   // entry fetch
   logic [psec_pkg::BEAT_W-1:0] beat_ff;
   logic [AW-1:0]   rd_addr_ff;
   logic [3*BW-1:0] ent_ff;
   logic [31:0]     ent_word;
   logic [PCW-1:0]  k_ff, cnt_ff;
   logic            emit_next_ff;
   logic            rd_en;

   // result registers
   logic           kind_ff, last_ff, cn_ff, nstart_ff;
   logic [7:0]     tid_ff, sn_ff, lsn_ff;
   logic [11:0]    slen_ff;
   logic [15:0]    id_ff;
   logic [4:0]     ver_ff;
   logic [31:0]    crc_ff;

   assign wc_new   = wc_ff + WCW'(1);
   assign overflow = (wc_ff >= WCW'(SECTION_BYTES));
   assign len_new  = {hdr_ff[1][psec_pkg::LEN_FIELD_HI_W-1:0], req_data_byte};
   assign len_eff  = (wc_new == WCW'(psec_pkg::LEN_OVERHEAD)) ? len_new : len_ff;
   assign complete = (wc_new >= WCW'(psec_pkg::LEN_OVERHEAD)) &&
                     (SW'(wc_new) >= (SW'(len_eff) + SW'(psec_pkg::LEN_OVERHEAD)));
   assign emit_next = req_packet_start ? 1'b0 : next_ff;

   always_comb begin
      wr_req  = 1'b0;
      wr_en   = 1'b0;
      wc_in   = wc_ff;
      len_in  = len_ff;
      skip_in = skip_ff;
      drop_in = drop_ff;
      next_in = next_ff;
      stat.done       = 1'b0;
      stat.cnt_zero   = (cnt_ff == '0);
      stat.fetch_done = (beat_ff == psec_pkg::BEAT_W'(psec_pkg::ENTRY_BYTES));
      stat.last_entry = (PCW'(k_ff + PCW'(1)) == cnt_ff);
      if (cmd.take) begin
         priority if (req_packet_start) begin
            drop_in = 1'b0;
            next_in = 1'b0;
            skip_in = '0;
            priority if (wc_ff == '0) begin
               if (req_unit_start) skip_in = req_data_byte;
               else drop_in = 1'b1;
            end else if (req_unit_start) begin
               next_in = 1'b1;
            end else begin
               wr_req = 1'b1;
            end
         end else if (!drop_ff) begin
            if (skip_ff != '0) skip_in = skip_ff - BW'(1);
            else wr_req = 1'b1;
         end else begin
            wr_req = 1'b0;
         end
      end
      if (wr_req) begin
         if (!overflow) begin
            wr_en = 1'b1;
            wc_in = wc_new;
            if (wc_new == WCW'(psec_pkg::LEN_OVERHEAD)) len_in = len_new;
            stat.done = complete;
         end
         // overflow or finished section: clear and drop the rest of the packet
         if (overflow || complete) begin
            wc_in   = '0;
            len_in  = '0;
            skip_in = '0;
            next_in = 1'b0;
            drop_in = 1'b1;
         end
      end
   end

   // header bytes as seen after this write, zero where not yet written
   always_comb begin
      for (int i = 0; i < psec_pkg::HDR_BYTES; i++) begin
         hdr_now[i] = (wr_en && (wc_ff == WCW'(i))) ? req_data_byte : hdr_ff[i];
         hdr_m[i]   = (WCW'(i) < wc_new) ? hdr_now[i] : '0;
      end
   end

   // CRC is the last four bytes written, or zero when the section length is under CRC_MIN_LEN
   assign crc_word = (len_eff >= LW'(psec_pkg::CRC_MIN_LEN)) ? {tail_ff, req_data_byte} : '0;

   always_comb begin
      len_diff = len_eff - LW'(psec_pkg::ENTRY_MIN_LEN);
      cnt_raw  = len_diff[LW-1:2];
      if (len_eff < LW'(psec_pkg::ENTRY_MIN_LEN)) cnt_new = '0;
      else if (cnt_raw > QW'(MAX_PROGRAMS)) cnt_new = PCW'(MAX_PROGRAMS);
      else cnt_new = PCW'(cnt_raw);
   end

   assign rd_en    = cmd.fetch && (beat_ff != psec_pkg::BEAT_W'(psec_pkg::ENTRY_BYTES));
   assign ent_word = {ent_ff, rd_data_ff};

   always_ff @(posedge clock) begin
      if (wr_en) mem[wc_ff[AW-1:0]] <= req_data_byte;
      if (rd_en) rd_data_ff <= mem[rd_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wc_ff   <= '0;
         len_ff  <= '0;
         skip_ff <= '0;
         drop_ff <= 1'b1;
         next_ff <= 1'b0;
         beat_ff <= '0;
      end else begin
         wc_ff   <= wc_in;
         len_ff  <= len_in;
         skip_ff <= skip_in;
         drop_ff <= drop_in;
         next_ff <= next_in;
         if (cmd.fetch_start || cmd.next_entry) beat_ff <= '0;
         else if (rd_en) beat_ff <= beat_ff + psec_pkg::BEAT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < psec_pkg::HDR_BYTES; i++) begin
         if (wr_en && (wc_ff == WCW'(i))) hdr_ff[i] <= req_data_byte;
      end
      if (wr_en) tail_ff <= {tail_ff[2*BW-1:0], req_data_byte};

      if (cmd.fetch_start) begin
         rd_addr_ff <= AW'(psec_pkg::ENTRY_BASE);
         k_ff       <= '0;
      end else begin
         if (rd_en) rd_addr_ff <= rd_addr_ff + AW'(1);
         if (cmd.next_entry) k_ff <= k_ff + PCW'(1);
      end
      if (cmd.fetch && (beat_ff != '0) && rd_en) ent_ff <= {ent_ff[2*BW-1:0], rd_data_ff};

      if (stat.done) begin
         cnt_ff       <= cnt_new;
         emit_next_ff <= emit_next;
         kind_ff      <= psec_pkg::KIND_HEADER;
         last_ff      <= (cnt_new == '0);
         tid_ff       <= hdr_m[0];
         slen_ff      <= len_eff;
         id_ff        <= {hdr_m[3], hdr_m[4]};
         ver_ff       <= hdr_m[5][5:1];
         cn_ff        <= hdr_m[5][0];
         sn_ff        <= hdr_m[6];
         lsn_ff       <= hdr_m[7];
         crc_ff       <= crc_word;
         nstart_ff    <= emit_next;
      end else if (cmd.load_entry) begin
         kind_ff      <= psec_pkg::KIND_ENTRY;
         last_ff      <= stat.last_entry;
         tid_ff       <= '0;
         slen_ff      <= '0;
         id_ff        <= ent_word[31:16];
         ver_ff       <= '0;
         cn_ff        <= 1'b0;
         sn_ff        <= '0;
         lsn_ff       <= '0;
         crc_ff       <= {16'h0000, ent_word[15:0]};
         nstart_ff    <= emit_next_ff;
      end
   end

   assign rsp_kind             = kind_ff;
   assign rsp_last             = last_ff;
   assign rsp_table_ident      = tid_ff;
   assign rsp_section_len      = slen_ff;
   assign rsp_id_or_program    = id_ff;
   assign rsp_version          = ver_ff;
   assign rsp_current_next     = cn_ff;
   assign rsp_section_num      = sn_ff;
   assign rsp_last_section_num = lsn_ff;
   assign rsp_crc_or_pid       = crc_ff;
   assign rsp_next_started     = nstart_ff;

endmodule

// ----- rtl/psi_section_pat_extractor.sv -----
// Usage notes for psi_section_pat_extractor
// Input channel (req_*): one payload byte of a PID-filtered transport packet
// per item, tagged with packet start and the packet's unit start flag. The
// block follows the pointer field, collects one PSI section until its length
// plus 3 bytes are held, then returns results on the rsp_* channel: one header
// item and then one item per program entry (at most MAX_PROGRAMS), rsp_last on
// the final one. The CRC is passed through raw, not checked. A section that
// overruns SECTION_BYTES is dropped without a result.
// Throughput: one byte per cycle while a section is being collected. The byte
// that completes a section puts the header on rsp_* the next cycle; each
// entry is then read out of the section memory, its four bytes in turn,
// after the previous item is taken. req_ready is low from the completing byte
// until the last result of the section is taken, so a stalled receiver holds
// the input side. Results stay registered and unchanged while rsp_ready is low.
// Reset (synchronous, active high) empties the section and waits for the next
// packet start; the section memory needs no clearing pass.
// Depends on psec_pkg, psec_ctrl and psec_dpath.
module psi_section_pat_extractor #(
   parameter int SECTION_BYTES = psec_pkg::DEF_SECTION_BYTES,
   parameter int MAX_PROGRAMS  = psec_pkg::DEF_MAX_PROGRAMS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_packet_start,
   input  logic        req_unit_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic        rsp_last,
   output logic [7:0]  rsp_table_ident,
   output logic [11:0] rsp_section_len,
   output logic [15:0] rsp_id_or_program,
   output logic [4:0]  rsp_version,
   output logic        rsp_current_next,
   output logic [7:0]  rsp_section_num,
   output logic [7:0]  rsp_last_section_num,
   output logic [31:0] rsp_crc_or_pid,
   output logic        rsp_next_started
);

   psec_pkg::psec_cmd_type  cmd;
   psec_pkg::psec_stat_type stat;

   psec_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   psec_dpath #(
      .SECTION_BYTES (SECTION_BYTES),
      .MAX_PROGRAMS  (MAX_PROGRAMS)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .req_data_byte        (req_data_byte),
      .req_packet_start     (req_packet_start),
      .req_unit_start       (req_unit_start),
      .rsp_kind             (rsp_kind),
      .rsp_last             (rsp_last),
      .rsp_table_ident      (rsp_table_ident),
      .rsp_section_len      (rsp_section_len),
      .rsp_id_or_program    (rsp_id_or_program),
      .rsp_version          (rsp_version),
      .rsp_current_next     (rsp_current_next),
      .rsp_section_num      (rsp_section_num),
      .rsp_last_section_num (rsp_last_section_num),
      .rsp_crc_or_pid       (rsp_crc_or_pid),
      .rsp_next_started     (rsp_next_started)
   );

   // input side is closed whenever a result is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input open while a result is pending");

   a_reopen_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last) |=> req_ready)
      else $error("input not reopened after last result");

   a_hold_mid_section: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=> (!req_ready && !rsp_valid))
      else $error("input reopened or result shown early in the middle of a section");

   a_entry_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == psec_pkg::KIND_ENTRY)) |->
         ((rsp_crc_or_pid[31:16] == 16'h0000) && (rsp_section_len == 12'h000)))
      else $error("entry result carries header fields");

endmodule

// ----- bench/psi_section_pat_extractor_tb.sv -----
// Self-checking bench for psi_section_pat_extractor: PSI section reassembly
// and PAT header/program item extraction, checked against a local predictor.
// Depends on psec_pkg and the RTL of psi_section_pat_extractor only.
module psi_section_pat_extractor_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SEC_BYTES  = psec_pkg::DEF_SECTION_BYTES;
   localparam int MAX_PROG   = psec_pkg::DEF_MAX_PROGRAMS;
   localparam int QUIET_TAIL = 120;
   localparam int BIG_CAP    = 5000;

   typedef struct {
      logic [7:0] data;
      logic       pkt_start;
      logic       unit_start;
      bit         drain;
   } ts_byte_type;

   typedef struct packed {
      logic        kind;
      logic        last;
      logic [7:0]  table_ident;
      logic [11:0] section_len;
      logic [15:0] id_or_program;
      logic [4:0]  version;
      logic        current_next;
      logic [7:0]  section_num;
      logic [7:0]  last_section_num;
      logic [31:0] crc_or_pid;
      logic        next_started;
   } pat_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic        req_packet_start = 1'b0;
   logic        req_unit_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_kind;
   logic        rsp_last;
   logic [7:0]  rsp_table_ident;
   logic [11:0] rsp_section_len;
   logic [15:0] rsp_id_or_program;
   logic [4:0]  rsp_version;
   logic        rsp_current_next;
   logic [7:0]  rsp_section_num;
   logic [7:0]  rsp_last_section_num;
   logic [31:0] rsp_crc_or_pid;
   logic        rsp_next_started;

   ts_byte_type    byte_queue[$];
   pat_result_type pat_due[$];
   int unsigned errors = 0;
   int unsigned src_gap = 0;
   int unsigned sink_gap = 0;
   bit          calm = 1'b0;

   // predictor state
   logic [7:0]  sec_mem [SEC_BYTES];
   int unsigned sec_fill = 0;
   int unsigned sec_len = 0;
   int unsigned ptr_skip = 0;
   bit          pkt_drop = 1'b1;
   bit          new_sec_flag = 1'b0;

   psi_section_pat_extractor #(
      .SECTION_BYTES(SEC_BYTES),
      .MAX_PROGRAMS (MAX_PROG)
   ) u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data_byte       (req_data_byte),
      .req_packet_start    (req_packet_start),
      .req_unit_start      (req_unit_start),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_kind            (rsp_kind),
      .rsp_last            (rsp_last),
      .rsp_table_ident     (rsp_table_ident),
      .rsp_section_len     (rsp_section_len),
      .rsp_id_or_program   (rsp_id_or_program),
      .rsp_version         (rsp_version),
      .rsp_current_next    (rsp_current_next),
      .rsp_section_num     (rsp_section_num),
      .rsp_last_section_num(rsp_last_section_num),
      .rsp_crc_or_pid      (rsp_crc_or_pid),
      .rsp_next_started    (rsp_next_started)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // positions past the fill level read as zero
   function automatic logic [7:0] sec_byte(int unsigned idx);
      return (idx < sec_fill && idx < SEC_BYTES) ? sec_mem[idx] : 8'h00;
   endfunction

   task automatic drop_section();
      sec_fill = 0;
      sec_len = 0;
      ptr_skip = 0;
      new_sec_flag = 1'b0;
      pkt_drop = 1'b1;
   endtask

   task automatic emit_pat();
      int unsigned cnt;
      int unsigned b;
      int unsigned k;
      pat_result_type r;
      logic [7:0]  vb;
      cnt = (sec_len >= psec_pkg::ENTRY_MIN_LEN) ?
            (sec_len - psec_pkg::ENTRY_MIN_LEN) / psec_pkg::ENTRY_BYTES : 0;
      if (cnt > MAX_PROG) begin
         cnt = MAX_PROG;
      end
      vb = sec_byte(5);
      r = '0;
      r.kind = psec_pkg::KIND_HEADER;
      r.last = (cnt == 0);
      r.table_ident = sec_byte(0);
      r.section_len = sec_len[psec_pkg::LEN_W-1:0];
      r.id_or_program = {sec_byte(3), sec_byte(4)};
      r.version = vb[5:1];
      r.current_next = vb[0];
      r.section_num = sec_byte(6);
      r.last_section_num = sec_byte(7);
      if (sec_len >= psec_pkg::CRC_MIN_LEN) begin
         r.crc_or_pid = {sec_byte(sec_len - 1), sec_byte(sec_len),
                         sec_byte(sec_len + 1), sec_byte(sec_len + 2)};
      end
      r.next_started = new_sec_flag;
      pat_due.push_back(r);
      for (k = 0; k < cnt; k++) begin
         b = psec_pkg::ENTRY_BASE + psec_pkg::ENTRY_BYTES * k;
         r = '0;
         r.kind = psec_pkg::KIND_ENTRY;
         r.last = (k + 1 == cnt);
         r.id_or_program = {sec_byte(b), sec_byte(b + 1)};
         r.crc_or_pid = {16'h0000, sec_byte(b + 2), sec_byte(b + 3)};
         r.next_started = new_sec_flag;
         pat_due.push_back(r);
      end
   endtask

   task automatic reassemble_byte(input logic [7:0] b, input logic ps, input logic us);
      bit keep;
      keep = 1'b1;
      if (ps) begin
         pkt_drop = 1'b0;
         new_sec_flag = 1'b0;
         ptr_skip = 0;
         if (sec_fill == 0) begin
            // idle: pointer field opens a section, no unit start drops the packet
            if (!us) begin
               pkt_drop = 1'b1;
            end else begin
               ptr_skip = 32'(b);
            end
            keep = 1'b0;
         end else if (us) begin
            new_sec_flag = 1'b1;
            keep = 1'b0;
         end
      end else if (pkt_drop) begin
         keep = 1'b0;
      end else if (ptr_skip > 0) begin
         ptr_skip--;
         keep = 1'b0;
      end
      if (keep) begin
         if (sec_fill >= SEC_BYTES) begin
            drop_section();
         end else begin
            sec_mem[sec_fill] = b;
            sec_fill++;
            if (sec_fill == psec_pkg::LEN_OVERHEAD) begin
               sec_len = ((int'(sec_byte(1)) << psec_pkg::BYTE_W) | int'(sec_byte(2)))
                         & ((1 << psec_pkg::LEN_W) - 1);
            end
            if (sec_fill >= psec_pkg::LEN_OVERHEAD &&
                sec_fill >= sec_len + psec_pkg::LEN_OVERHEAD) begin
               emit_pat();
               drop_section();
            end
         end
      end
   endtask

   task automatic queue_byte(input logic [7:0] b, input logic ps, input logic us);
      ts_byte_type t;
      t.data = b;
      t.pkt_start = ps;
      t.unit_start = us;
      t.drain = 1'b0;
      byte_queue.push_back(t);
   endtask

   task automatic queue_drain();
      ts_byte_type t;
      t.data = '0;
      t.pkt_start = 1'b0;
      t.unit_start = 1'b0;
      t.drain = 1'b1;
      byte_queue.push_back(t);
   endtask

   // one section behind a pointer field, split over packets of random size
   task automatic queue_section(input int unsigned len, input int unsigned ptr,
                                input int unsigned max_chunk, input int unsigned cap);
      logic [7:0]  body[$];
      int unsigned i;
      int unsigned chunk;
      logic        us;
      body.push_back(8'($urandom));
      body.push_back({4'($urandom), 4'(len >> 8)});
      body.push_back(8'(len));
      while (body.size() < len + psec_pkg::LEN_OVERHEAD && body.size() < cap) begin
         body.push_back(8'($urandom));
      end
      queue_byte(8'(ptr), 1'b1, 1'b1);
      repeat (ptr) queue_byte(8'($urandom), 1'b0, 1'b1);
      us = 1'b1;
      chunk = $urandom_range(1, max_chunk);
      for (i = 0; i < body.size(); i++) begin
         if (chunk == 0) begin
            chunk = $urandom_range(1, max_chunk);
            us = ($urandom_range(0, 7) == 0);
            if (us) begin
               // continuation packet with its own pointer byte
               queue_byte(8'($urandom), 1'b1, 1'b1);
               queue_byte(body[i], 1'b0, 1'b1);
            end else begin
               queue_byte(body[i], 1'b1, 1'b0);
            end
         end else begin
            queue_byte(body[i], 1'b0, us);
         end
         chunk--;
      end
      repeat ($urandom_range(0, 4)) queue_byte(8'($urandom), 1'b0, us);
   endtask

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   // input side
   always @(posedge clock) begin
      ts_byte_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            reassemble_byte(req_data_byte, req_packet_start, req_unit_start);
         end
         calm <= (byte_queue.size() < QUIET_TAIL);
         if (!req_valid || req_ready) begin
            if (src_gap > 0) begin
               src_gap--;
               req_valid <= 1'b0;
            end else if (byte_queue.size() > 0 && byte_queue[0].drain) begin
               // hold off until every pending result has been taken
               req_valid <= 1'b0;
               if (pat_due.size() == 0) begin
                  void'(byte_queue.pop_front());
               end
            end else if (byte_queue.size() > 0) begin
               nxt = byte_queue.pop_front();
               req_valid <= 1'b1;
               req_data_byte <= nxt.data;
               req_packet_start <= nxt.pkt_start;
               req_unit_start <= nxt.unit_start;
               if (!calm && $urandom_range(0, 9) == 0) begin
                  src_gap = $urandom_range(1, 16);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result side
   always @(posedge clock) begin
      pat_result_type seen;
      pat_result_type due;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_kind, rsp_last, rsp_table_ident, rsp_section_len, rsp_id_or_program,
                    rsp_version, rsp_current_next, rsp_section_num, rsp_last_section_num,
                    rsp_crc_or_pid, rsp_next_started};
            if (pat_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none, actual %h", $time, seen);
            end else begin
               due = pat_due.pop_front();
               check_field("kind", 32'(due.kind), 32'(seen.kind));
               check_field("last", 32'(due.last), 32'(seen.last));
               check_field("table_ident", 32'(due.table_ident), 32'(seen.table_ident));
               check_field("section_len", 32'(due.section_len), 32'(seen.section_len));
               check_field("id_or_program", 32'(due.id_or_program),
                           32'(seen.id_or_program));
               check_field("version", 32'(due.version), 32'(seen.version));
               check_field("current_next", 32'(due.current_next), 32'(seen.current_next));
               check_field("section_num", 32'(due.section_num), 32'(seen.section_num));
               check_field("last_section_num", 32'(due.last_section_num),
                           32'(seen.last_section_num));
               check_field("crc_or_pid", due.crc_or_pid, seen.crc_or_pid);
               check_field("next_started", 32'(due.next_started), 32'(seen.next_started));
            end
         end
         if (sink_gap > 0) begin
            sink_gap--;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            sink_gap = $urandom_range(0, 15);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      int unsigned seg;
      int unsigned counted;
      int unsigned mark;
      int unsigned pick;
      int unsigned lp;
      int unsigned len;
      int unsigned ptr;
      // idle packet without unit start is dropped
      queue_byte(8'hFF, 1'b1, 1'b0);
      queue_byte(8'h00, 1'b0, 1'b0);
      // pointer 1, length 5 with the reserved length nibble set; fills header bytes 0..7
      queue_byte(8'h01, 1'b1, 1'b1);
      queue_byte(8'hA5, 1'b0, 1'b1);
      queue_byte(8'h00, 1'b0, 1'b1);
      queue_byte(8'hF0, 1'b0, 1'b1);
      queue_byte(8'h05, 1'b0, 1'b1);
      queue_byte(8'hFF, 1'b0, 1'b1);
      queue_byte(8'hFF, 1'b0, 1'b1);
      queue_byte(8'hFF, 1'b0, 1'b1);
      queue_byte(8'h00, 1'b0, 1'b1);
      queue_byte(8'hFF, 1'b0, 1'b1);
      queue_byte(8'h3C, 1'b0, 1'b1);
      // zero length section
      queue_byte(8'h00, 1'b1, 1'b1);
      queue_byte(8'h42, 1'b0, 1'b1);
      queue_byte(8'h00, 1'b0, 1'b1);
      queue_byte(8'h00, 1'b0, 1'b1);
      // length 3, no CRC, completed in a packet that starts a new unit
      queue_byte(8'h00, 1'b1, 1'b1);
      queue_byte(8'h02, 1'b0, 1'b1);
      queue_byte(8'h80, 1'b0, 1'b1);
      queue_byte(8'h03, 1'b0, 1'b1);
      queue_byte(8'h7F, 1'b1, 1'b1);
      queue_byte(8'h11, 1'b0, 1'b1);
      queue_byte(8'h22, 1'b0, 1'b1);
      queue_byte(8'h33, 1'b0, 1'b1);
      queue_byte(8'hEE, 1'b0, 1'b1);
      queue_drain();

      seg = 0;
      counted = byte_queue.size();
      while (counted < 400) begin
         mark = byte_queue.size();
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            repeat ($urandom_range(1, 12)) begin
               queue_byte(8'($urandom), $urandom_range(0, 3) == 0, 1'($urandom));
            end
         end else begin
            if (pick < 15) begin
               // long pointer cut short by the next packet start
               queue_byte(8'($urandom_range(8, 255)), 1'b1, 1'b1);
               repeat ($urandom_range(0, 6)) queue_byte(8'($urandom), 1'b0, 1'b1);
            end
            lp = $urandom_range(0, 19);
            len = (lp < 7) ? $urandom_range(0, 12) :
                  (lp < 16 && seg != 3) ? $urandom_range(13, 72) : $urandom_range(73, 110);
            ptr = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
            queue_section(len, ptr,
                          ($urandom_range(0, 4) == 0) ? 184 : $urandom_range(2, 40), BIG_CAP);
         end
         counted += byte_queue.size() - mark;
         if (seg == 5 || seg == 20) begin
            queue_drain();
         end
         seg++;
      end

      while (reset) @(posedge clock);
      while (byte_queue.size() != 0 || req_valid || pat_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0 && pat_due.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

// ----- psi_section_pat_extractor.f -----
rtl/psec_pkg.sv
rtl/psec_ctrl.sv
rtl/psec_dpath.sv
rtl/psi_section_pat_extractor.sv
bench/psi_section_pat_extractor_tb.sv
